@@ rtl/assert_macros.svh @@
// Assertion macros of the ray triangle intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is high.
`define RTI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define RTI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/rti_pkg.sv @@
// Package with widths, types, register codes and multiply helpers of the intersection unit.
package rti_pkg;

   // Fixed point format and datapath widths.
   localparam int FRAC_BITS = 16;
   localparam int CW  = 32;                   // coordinate
   localparam int EW  = CW + 1;               // edge or origin offset
   localparam int PW  = 2 * EW;               // one cross product term
   localparam int XW  = PW + 1;               // cross product component
   localparam int SPL = EW + 1;               // split point of a cross component
   localparam int HW  = XW - SPL;             // upper slice of a cross component
   localparam int HPW = HW + EW;              // upper partial product
   localparam int LPW = SPL + 1 + EW;         // lower partial product
   localparam int DW  = XW + EW + 2;          // dot product
   localparam int DWX = DW + 1;               // sum of two dot products
   localparam int QW  = CW - 1;               // quotient bits
   localparam int TW  = DW + QW - FRAC_BITS;  // saturation compare
   localparam int RW  = DW + QW;              // divider remainder
   localparam int MW  = 2 * CW + 1;           // hit point product
   localparam int SW  = MW - FRAC_BITS + 1;   // hit point sum
   localparam int IW  = 3;                    // register index

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed { coord_type x; coord_type y; coord_type z; } vec_type;
   typedef struct packed { vec_type a; vec_type b; vec_type c; } trgl_type;
   typedef struct packed { vec_type org; vec_type dir; logic [CW-1:0] thr; } ray_type;

   typedef logic [2:0][XW-1:0] xvec_type;
   typedef logic [2:0][EW-1:0] evec_type;
   typedef struct packed {
      xvec_type pv;
      xvec_type qv;
      evec_type ab;
      evec_type ac;
      evec_type s;
   } geo_type;

   typedef struct packed {
      logic          miss;
      logic          sat;
      logic [DW-1:0] t;
      logic [DW-1:0] det;
   } quot_req_type;

   typedef struct packed {
      logic          miss;
      logic          sat;
      logic [QW-1:0] q;
   } quot_type;

   typedef struct packed {
      logic      hit;
      coord_type distance;
      vec_type   point;
   } rsp_type;

   // Configuration register indexes.
   typedef enum logic [IW-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_ORIGIN_Z    = 3'd2,
      CSR_DIRECTION_X = 3'd3,
      CSR_DIRECTION_Y = 3'd4,
      CSR_DIRECTION_Z = 3'd5,
      CSR_THRESHOLD   = 3'd6
   } csr_index_type;

   localparam coord_type   DIR_Z_RESET = CW'(1 << FRAC_BITS);
   localparam logic [CW-1:0] THR_RESET = CW'(1);
   localparam ray_type RAY_RESET = '{
      org: '0,
      dir: '{x: '0, y: '0, z: DIR_Z_RESET},
      thr: THR_RESET
   };
   localparam logic [CW-1:0] DIST_SAT = {1'b0, {QW{1'b1}}};

   // Signed product of the edge-wide operands a and b, PW bits wide.
   function automatic logic signed [PW-1:0] mul_ee(logic signed [EW-1:0] a,
                                                  logic signed [EW-1:0] b);
      logic signed [PW-1:0] ax;
      logic signed [PW-1:0] bx;
      ax = PW'(a);
      bx = PW'(b);
      return ax * bx;
   endfunction

   // Upper slice of a cross component times an edge-wide operand.
   function automatic logic signed [HPW-1:0] mul_hi(logic signed [XW-1:0] x,
                                                   logic signed [EW-1:0] y);
      logic signed [HPW-1:0] hx;
      logic signed [HPW-1:0] yx;
      hx = HPW'($signed(x[XW-1:SPL]));
      yx = HPW'(y);
      return hx * yx;
   endfunction

   // Lower slice (taken as unsigned) of a cross component times an edge-wide operand.
   function automatic logic signed [LPW-1:0] mul_lo(logic signed [XW-1:0] x,
                                                   logic signed [EW-1:0] y);
      logic signed [LPW-1:0] lx;
      logic signed [LPW-1:0] yx;
      lx = $signed(LPW'(x[SPL-1:0]));
      yx = LPW'(y);
      return lx * yx;
   endfunction

endpackage

@@ rtl/rti_if.sv @@
// Channel interfaces of the intersection unit: triangle input, result output, register writes.
interface rti_req_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] c_x;
   logic signed [31:0] c_y;
   logic signed [31:0] c_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface rti_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] distance;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, hit, distance, point_x, point_y, point_z, input ready);
   modport sink (input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface

interface rti_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ray_triangle_intersection_unit.sv @@
// Top level of the ray triangle intersection unit: ray registers, pipeline and result buffer.
//
//   Port    Direction  Carries
//   req_ch  in         triangle vertices a, b, c, nine signed Q16.16 words
//   rsp_ch  out        hit, distance, point_x, point_y, point_z
//   csr_ch  in         register index (3 bits) and 32-bit write data
//
// One triangle is taken per cycle while req_ch.ready is high.
// Most of the latency is the 31-stage divider that forms one distance bit per stage.
// Reset is synchronous; it clears the valid bits and loads the ray registers with their reset values.
// When rsp_ch is held off, one more result enters a skid register; the pipeline
// then freezes as a whole and req_ch.ready stays low until the skid register drains.
`include "assert_macros.svh"

module ray_triangle_intersection_unit (
   input logic       clock,
   input logic       reset,
   rti_req_if.sink   req_ch,
   rti_rsp_if.source rsp_ch,
   rti_csr_if.sink   csr_ch
);

   rti_pkg::ray_type      ray_ff;
   rti_pkg::trgl_type     trgl;
   logic                  en;
   logic                  geo_valid;
   rti_pkg::geo_type      geo;
   logic                  req_valid;
   rti_pkg::quot_req_type quot_req;
   logic                  quot_valid;
   rti_pkg::quot_type     quot;
   logic                  pipe_valid;
   rti_pkg::rsp_type      pipe_rsp;
   logic                  out_vld_ff;
   rti_pkg::rsp_type      out_ff;
   logic                  skid_vld_ff;
   rti_pkg::rsp_type      skid_ff;
   logic                  take;

   // Ray registers; writes to an index past the list are dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= rti_pkg::RAY_RESET;
      end else if (csr_ch.valid) begin
         case (rti_pkg::csr_index_type'(csr_ch.index))
            rti_pkg::CSR_ORIGIN_X:    ray_ff.org.x <= csr_ch.data;
            rti_pkg::CSR_ORIGIN_Y:    ray_ff.org.y <= csr_ch.data;
            rti_pkg::CSR_ORIGIN_Z:    ray_ff.org.z <= csr_ch.data;
            rti_pkg::CSR_DIRECTION_X: ray_ff.dir.x <= csr_ch.data;
            rti_pkg::CSR_DIRECTION_Y: ray_ff.dir.y <= csr_ch.data;
            rti_pkg::CSR_DIRECTION_Z: ray_ff.dir.z <= csr_ch.data;
            rti_pkg::CSR_THRESHOLD:   ray_ff.thr   <= csr_ch.data;
            default:                  ray_ff       <= ray_ff;
         endcase
      end
   end

   // The pipeline moves whenever the skid register is empty.
   assign en           = !skid_vld_ff;
   assign req_ch.ready = en;

   assign trgl.a.x = req_ch.a_x;
   assign trgl.a.y = req_ch.a_y;
   assign trgl.a.z = req_ch.a_z;
   assign trgl.b.x = req_ch.b_x;
   assign trgl.b.y = req_ch.b_y;
   assign trgl.b.z = req_ch.b_z;
   assign trgl.c.x = req_ch.c_x;
   assign trgl.c.y = req_ch.c_y;
   assign trgl.c.z = req_ch.c_z;

   rti_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_trgl   (trgl),
      .ray       (ray_ff),
      .out_valid (geo_valid),
      .out_geo   (geo)
   );

   rti_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geo_valid),
      .in_geo    (geo),
      .ray       (ray_ff),
      .out_valid (req_valid),
      .out_req   (quot_req)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (quot_req),
      .out_valid (quot_valid),
      .out_quot  (quot)
   );

   rti_point u_point (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (quot_valid),
      .in_quot   (quot),
      .ray       (ray_ff),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   // Output register with a skid register behind it.
   assign take = !out_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (take) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= pipe_valid;
         end
      end else if (en && pipe_valid) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= skid_vld_ff ? skid_ff : pipe_rsp;
      end else if (en && pipe_valid) begin
         skid_ff <= pipe_rsp;
      end
   end

   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.hit      = out_ff.hit;
   assign rsp_ch.distance = out_ff.distance;
   assign rsp_ch.point_x  = out_ff.point.x;
   assign rsp_ch.point_y  = out_ff.point.y;
   assign rsp_ch.point_z  = out_ff.point.z;

   // The skid register only holds a result behind a full output register.
   `RTI_ASSERT_ALWAYS(a_skid_behind_out, clock, (skid_vld_ff |-> out_vld_ff), "skid without output")
   // The skid register fills only when the output was held off.
   `RTI_ASSERT(a_skid_fill, clock, reset, ($rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_ch.ready)), "skid filled without stall")
   // A hit always carries a positive distance.
   `RTI_ASSERT(a_hit_distance, clock, reset, ((out_vld_ff && out_ff.hit) |-> (out_ff.distance > 0)), "hit with non-positive distance")
   // A miss carries all-zero fields.
   `RTI_ASSERT(a_miss_zero, clock, reset, ((out_vld_ff && !out_ff.hit) |-> (out_ff.distance == '0 && out_ff.point == '0)), "miss with nonzero fields")

endmodule

@@ rtl/rti_geom.sv @@
// Front pipeline: edges, origin offset and the two cross products, three stages.
module rti_geom (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rti_pkg::trgl_type in_trgl,
   input  rti_pkg::ray_type  ray,
   output logic              out_valid,
   output rti_pkg::geo_type  out_geo
);

   logic signed [rti_pkg::CW-1:0] av [3];
   logic signed [rti_pkg::CW-1:0] bv [3];
   logic signed [rti_pkg::CW-1:0] cv [3];
   logic signed [rti_pkg::CW-1:0] ov [3];
   logic signed [rti_pkg::CW-1:0] dv [3];

   logic signed [rti_pkg::EW-1:0] ab_in [3];
   logic signed [rti_pkg::EW-1:0] ac_in [3];
   logic signed [rti_pkg::EW-1:0] s_in [3];
   logic signed [rti_pkg::EW-1:0] ab1_ff [3];
   logic signed [rti_pkg::EW-1:0] ac1_ff [3];
   logic signed [rti_pkg::EW-1:0] s1_ff [3];
   logic signed [rti_pkg::EW-1:0] ab2_ff [3];
   logic signed [rti_pkg::EW-1:0] ac2_ff [3];
   logic signed [rti_pkg::EW-1:0] s2_ff [3];
   logic signed [rti_pkg::PW-1:0] pa_ff [3];
   logic signed [rti_pkg::PW-1:0] pb_ff [3];
   logic signed [rti_pkg::PW-1:0] qa_ff [3];
   logic signed [rti_pkg::PW-1:0] qb_ff [3];
   rti_pkg::geo_type              geo_ff;
   logic [2:0]                    vld_ff;

   // Axis views of the vertices and the ray.
   assign av[0] = in_trgl.a.x;
   assign av[1] = in_trgl.a.y;
   assign av[2] = in_trgl.a.z;
   assign bv[0] = in_trgl.b.x;
   assign bv[1] = in_trgl.b.y;
   assign bv[2] = in_trgl.b.z;
   assign cv[0] = in_trgl.c.x;
   assign cv[1] = in_trgl.c.y;
   assign cv[2] = in_trgl.c.z;
   assign ov[0] = ray.org.x;
   assign ov[1] = ray.org.y;
   assign ov[2] = ray.org.z;
   assign dv[0] = ray.dir.x;
   assign dv[1] = ray.dir.y;
   assign dv[2] = ray.dir.z;

   // Valid bits travel with the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      // Stage one: edges and the offset of the origin from the first vertex.
      always_comb begin
         ab_in[i] = rti_pkg::EW'(bv[i]) - rti_pkg::EW'(av[i]);
         ac_in[i] = rti_pkg::EW'(cv[i]) - rti_pkg::EW'(av[i]);
         s_in[i]  = rti_pkg::EW'(ov[i]) - rti_pkg::EW'(av[i]);
      end

      // Stage two: the cross product terms; stage three: their differences.
      always_ff @(posedge clock) begin
         if (en) begin
            ab1_ff[i] <= ab_in[i];
            ac1_ff[i] <= ac_in[i];
            s1_ff[i]  <= s_in[i];
            pa_ff[i]  <= rti_pkg::mul_ee(rti_pkg::EW'(dv[J]), ac1_ff[K]);
            pb_ff[i]  <= rti_pkg::mul_ee(rti_pkg::EW'(dv[K]), ac1_ff[J]);
            qa_ff[i]  <= rti_pkg::mul_ee(s1_ff[J], ab1_ff[K]);
            qb_ff[i]  <= rti_pkg::mul_ee(s1_ff[K], ab1_ff[J]);
            ab2_ff[i] <= ab1_ff[i];
            ac2_ff[i] <= ac1_ff[i];
            s2_ff[i]  <= s1_ff[i];
            geo_ff.pv[i] <= rti_pkg::XW'(pa_ff[i]) - rti_pkg::XW'(pb_ff[i]);
            geo_ff.qv[i] <= rti_pkg::XW'(qa_ff[i]) - rti_pkg::XW'(qb_ff[i]);
            geo_ff.ab[i] <= ab2_ff[i];
            geo_ff.ac[i] <= ac2_ff[i];
            geo_ff.s[i]  <= s2_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign out_geo   = geo_ff;

endmodule

@@ rtl/rti_dot.sv @@
// Dot products for determinant, u, v and t, sign fold and the hit tests, five stages.
module rti_dot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rti_pkg::geo_type      in_geo,
   input  rti_pkg::ray_type      ray,
   output logic                  out_valid,
   output rti_pkg::quot_req_type out_req
);

   localparam int DET = 0;
   localparam int UU  = 1;
   localparam int VV  = 2;
   localparam int TT  = 3;

   logic signed [rti_pkg::CW-1:0]  dv [3];
   logic signed [rti_pkg::HPW-1:0] hp_ff [4][3];
   logic signed [rti_pkg::LPW-1:0] lp_ff [4][3];
   logic signed [rti_pkg::DW-1:0]  term_ff [4][3];
   logic signed [rti_pkg::DW-1:0]  dot_ff [4];
   logic signed [rti_pkg::DW-1:0]  mag_ff [4];
   logic                           neg;
   logic                           parallel;
   logic                           u_bad;
   logic                           v_bad;
   logic                           t_bad;
   logic                           sat;
   logic [rti_pkg::DW-1:0]         thr_w;
   logic signed [rti_pkg::DWX-1:0] uv_sum;
   rti_pkg::quot_req_type          req_ff;
   logic [4:0]                     vld_ff;

   assign dv[0] = ray.dir.x;
   assign dv[1] = ray.dir.y;
   assign dv[2] = ray.dir.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // Stage one: split partial products; stage two: each product rebuilt.
   for (genvar i = 0; i < 3; i++) begin : g_term
      always_ff @(posedge clock) begin
         if (en) begin
            hp_ff[DET][i] <= rti_pkg::mul_hi($signed(in_geo.pv[i]), $signed(in_geo.ab[i]));
            lp_ff[DET][i] <= rti_pkg::mul_lo($signed(in_geo.pv[i]), $signed(in_geo.ab[i]));
            hp_ff[UU][i]  <= rti_pkg::mul_hi($signed(in_geo.pv[i]), $signed(in_geo.s[i]));
            lp_ff[UU][i]  <= rti_pkg::mul_lo($signed(in_geo.pv[i]), $signed(in_geo.s[i]));
            hp_ff[VV][i]  <= rti_pkg::mul_hi($signed(in_geo.qv[i]), rti_pkg::EW'(dv[i]));
            lp_ff[VV][i]  <= rti_pkg::mul_lo($signed(in_geo.qv[i]), rti_pkg::EW'(dv[i]));
            hp_ff[TT][i]  <= rti_pkg::mul_hi($signed(in_geo.qv[i]), $signed(in_geo.ac[i]));
            lp_ff[TT][i]  <= rti_pkg::mul_lo($signed(in_geo.qv[i]), $signed(in_geo.ac[i]));
         end
      end
      for (genvar d = 0; d < 4; d++) begin : g_dot
         always_ff @(posedge clock) begin
            if (en) begin
               term_ff[d][i] <= (rti_pkg::DW'(hp_ff[d][i]) <<< rti_pkg::SPL)
                                + rti_pkg::DW'(lp_ff[d][i]);
            end
         end
      end
   end

   // Stage three: the sums; stage four: fold the determinant sign into all four.
   for (genvar d = 0; d < 4; d++) begin : g_sum
      always_ff @(posedge clock) begin
         if (en) begin
            dot_ff[d] <= term_ff[d][0] + term_ff[d][1] + term_ff[d][2];
            mag_ff[d] <= neg ? -dot_ff[d] : dot_ff[d];
         end
      end
   end

   assign neg = dot_ff[DET][rti_pkg::DW-1];

   // Stage five: parallel, barycentric and distance tests.
   always_comb begin
      thr_w    = rti_pkg::DW'(ray.thr) << (2 * rti_pkg::FRAC_BITS);
      parallel = (mag_ff[DET] == '0) || ($unsigned(mag_ff[DET]) < thr_w);
      u_bad    = mag_ff[UU][rti_pkg::DW-1] || (mag_ff[UU] > mag_ff[DET]);
      uv_sum   = rti_pkg::DWX'(mag_ff[UU]) + rti_pkg::DWX'(mag_ff[VV]);
      v_bad    = mag_ff[VV][rti_pkg::DW-1] || (uv_sum > rti_pkg::DWX'(mag_ff[DET]));
      t_bad    = mag_ff[TT][rti_pkg::DW-1] || (mag_ff[TT] == '0);
      sat      = rti_pkg::TW'($unsigned(mag_ff[TT]))
                 >= (rti_pkg::TW'($unsigned(mag_ff[DET])) << (rti_pkg::QW - rti_pkg::FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff.miss <= parallel | u_bad | v_bad | t_bad;
         req_ff.sat  <= sat;
         req_ff.t    <= mag_ff[TT];
         req_ff.det  <= mag_ff[DET];
      end
   end

   assign out_valid = vld_ff[4];
   assign out_req   = req_ff;

endmodule

@@ rtl/rti_div.sv @@
// Restoring divider for t / det, one quotient bit per pipeline stage.
module rti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rti_pkg::quot_req_type in_req,
   output logic                  out_valid,
   output rti_pkg::quot_type     out_quot
);

   logic [rti_pkg::RW-1:0] rem_ff [rti_pkg::QW-1];
   logic [rti_pkg::DW-1:0] det_ff [rti_pkg::QW-1];
   logic [rti_pkg::QW-1:0] q_ff [rti_pkg::QW];
   logic                   miss_ff [rti_pkg::QW];
   logic                   sat_ff [rti_pkg::QW];
   logic                   vld_ff [rti_pkg::QW];

   for (genvar k = 0; k < rti_pkg::QW; k++) begin : g_step
      localparam int B = rti_pkg::QW - 1 - k;

      logic [rti_pkg::RW-1:0] rem_cur;
      logic [rti_pkg::DW-1:0] det_cur;
      logic [rti_pkg::QW-1:0] q_cur;
      logic                   miss_cur;
      logic                   sat_cur;
      logic                   vld_cur;
      logic [rti_pkg::RW-1:0] dsh;
      logic                   ge;
      logic [rti_pkg::QW-1:0] q_in;

      // The first stage loads the numerator t scaled by the fraction bits.
      if (k == 0) begin : g_first
         assign rem_cur  = rti_pkg::RW'(in_req.t) << rti_pkg::FRAC_BITS;
         assign det_cur  = in_req.det;
         assign q_cur    = '0;
         assign miss_cur = in_req.miss;
         assign sat_cur  = in_req.sat;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign det_cur  = det_ff[k-1];
         assign q_cur    = q_ff[k-1];
         assign miss_cur = miss_ff[k-1];
         assign sat_cur  = sat_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
      end

      // Compare against the shifted divisor and set this quotient bit.
      always_comb begin
         dsh     = rti_pkg::RW'(det_cur) << B;
         ge      = rem_cur >= dsh;
         q_in    = q_cur;
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]    <= q_in;
            miss_ff[k] <= miss_cur;
            sat_ff[k]  <= sat_cur;
         end
      end

      // The last stage needs neither remainder nor divisor.
      if (k < rti_pkg::QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? rem_cur - dsh : rem_cur;
               det_ff[k] <= det_cur;
            end
         end
      end
   end

   assign out_valid     = vld_ff[rti_pkg::QW-1];
   assign out_quot.miss = miss_ff[rti_pkg::QW-1];
   assign out_quot.sat  = sat_ff[rti_pkg::QW-1];
   assign out_quot.q    = q_ff[rti_pkg::QW-1];

endmodule

@@ rtl/rti_point.sv @@
// Distance saturation, hit decision and the saturated hit point, two stages.
module rti_point (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rti_pkg::quot_type in_quot,
   input  rti_pkg::ray_type  ray,
   output logic              out_valid,
   output rti_pkg::rsp_type  out_rsp
);

   logic signed [rti_pkg::CW-1:0] ov [3];
   logic signed [rti_pkg::CW-1:0] dv [3];
   logic [rti_pkg::CW-1:0]        dist_in;
   logic                          hit_in;
   logic                          hit_ff;
   logic [rti_pkg::CW-1:0]        dist_ff;
   logic signed [rti_pkg::MW-1:0] prod_ff [3];
   logic signed [rti_pkg::SW-1:0] sum [3];
   logic signed [rti_pkg::CW-1:0] pt [3];
   rti_pkg::rsp_type              rsp_ff;
   logic [1:0]                    vld_ff;

   assign ov[0] = ray.org.x;
   assign ov[1] = ray.org.y;
   assign ov[2] = ray.org.z;
   assign dv[0] = ray.dir.x;
   assign dv[1] = ray.dir.y;
   assign dv[2] = ray.dir.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   // A distance that quantizes to zero is no hit.
   always_comb begin
      dist_in = in_quot.sat ? rti_pkg::DIST_SAT : rti_pkg::CW'(in_quot.q);
      hit_in  = !in_quot.miss && (dist_in != '0);
   end

   // Stage one: direction times distance.
   for (genvar i = 0; i < 3; i++) begin : g_mul
      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[i] <= rti_pkg::MW'(dv[i]) * $signed(rti_pkg::MW'(dist_in));
         end
      end

      // Stage two: floor the scaled product, add the origin, clamp to 32 bits.
      always_comb begin
         sum[i] = rti_pkg::SW'(prod_ff[i] >>> rti_pkg::FRAC_BITS) + rti_pkg::SW'(ov[i]);
         if (sum[i][rti_pkg::SW-1:rti_pkg::CW-1] == '0
             || sum[i][rti_pkg::SW-1:rti_pkg::CW-1] == '1) begin
            pt[i] = sum[i][rti_pkg::CW-1:0];
         end else if (sum[i][rti_pkg::SW-1]) begin
            pt[i] = {1'b1, {(rti_pkg::CW-1){1'b0}}};
         end else begin
            pt[i] = {1'b0, {(rti_pkg::CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
         rsp_ff.hit      <= hit_ff;
         rsp_ff.distance <= hit_ff ? dist_ff : '0;
         rsp_ff.point.x  <= hit_ff ? pt[0] : '0;
         rsp_ff.point.y  <= hit_ff ? pt[1] : '0;
         rsp_ff.point.z  <= hit_ff ? pt[2] : '0;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_rsp   = rsp_ff;

endmodule

@@ bench/tb_ray_triangle_intersection_unit.sv @@
// Self-checking testbench of the ray triangle intersection unit.
`timescale 1ns / 100ps

module tb_ray_triangle_intersection_unit;

   typedef logic signed [191:0] wide_type;
   typedef wide_type wvec_type [3];

   localparam int PIPE_LATENCY = 42;
   localparam int DRAIN_LIMIT  = 200000;

   logic clock;
   logic reset;

   rti_req_if req_ch ();
   rti_rsp_if rsp_ch ();
   rti_csr_if csr_ch ();

   ray_triangle_intersection_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Copy of the ray registers as the block should hold them.
   rti_pkg::coord_type ray_org [3];
   rti_pkg::coord_type ray_dir [3];
   logic [31:0]        ray_thr;

   rti_pkg::rsp_type expected_hits [$];
   int               error_count;
   bit               steady_flow;
   bit               hold_request;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic wvec_type cross_wide(wvec_type p, wvec_type q);
      wvec_type r;
      r[0] = p[1] * q[2] - p[2] * q[1];
      r[1] = p[2] * q[0] - p[0] * q[2];
      r[2] = p[0] * q[1] - p[1] * q[0];
      return r;
   endfunction

   function automatic wide_type dot_wide(wvec_type p, wvec_type q);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   // Exact Moller-Trumbore test of one triangle against the current ray.
   function automatic rti_pkg::rsp_type predict_intersection(rti_pkg::trgl_type tr);
      rti_pkg::coord_type av [3];
      rti_pkg::coord_type bv [3];
      rti_pkg::coord_type cv [3];
      wvec_type           ab, ac, s, dv, pv, qv;
      wide_type           det, u, v, t, thr, q, p;
      logic               neg;
      rti_pkg::coord_type dist_q;
      rti_pkg::rsp_type   r;
      r = '0;
      av = '{tr.a.x, tr.a.y, tr.a.z};
      bv = '{tr.b.x, tr.b.y, tr.b.z};
      cv = '{tr.c.x, tr.c.y, tr.c.z};
      for (int i = 0; i < 3; i++) begin
         ab[i] = wide_type'(bv[i]) - wide_type'(av[i]);
         ac[i] = wide_type'(cv[i]) - wide_type'(av[i]);
         s[i]  = wide_type'(ray_org[i]) - wide_type'(av[i]);
         dv[i] = wide_type'(ray_dir[i]);
      end
      pv  = cross_wide(dv, ac);
      det = dot_wide(pv, ab);
      neg = det < 0;
      if (neg) det = -det;
      thr = wide_type'(ray_thr) <<< (2 * rti_pkg::FRAC_BITS);
      if (det == 0 || det < thr) return r;
      u = dot_wide(pv, s);
      if (neg) u = -u;
      if (u < 0 || u > det) return r;
      qv = cross_wide(s, ab);
      v  = dot_wide(qv, dv);
      if (neg) v = -v;
      if (v < 0 || u + v > det) return r;
      t = dot_wide(qv, ac);
      if (neg) t = -t;
      if (t <= 0) return r;
      q = (t <<< rti_pkg::FRAC_BITS) / det;
      if (q > wide_type'(rti_pkg::DIST_SAT)) q = wide_type'(rti_pkg::DIST_SAT);
      if (q == 0) return r;
      dist_q = rti_pkg::coord_type'(q);
      r.hit = 1'b1;
      r.distance = dist_q;
      for (int i = 0; i < 3; i++) begin
         // Arithmetic shift gives the floor of the scaled product.
         p = wide_type'(ray_org[i]) + ((dv[i] * q) >>> rti_pkg::FRAC_BITS);
         if (p > 64'sh7FFFFFFF) p = 64'sh7FFFFFFF;
         if (p < -64'sh80000000) p = -64'sh80000000;
         case (i)
            0: r.point.x = rti_pkg::coord_type'(p);
            1: r.point.y = rti_pkg::coord_type'(p);
            default: r.point.z = rti_pkg::coord_type'(p);
         endcase
      end
      return r;
   endfunction

   // Result checker: each transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      rti_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.hit, rsp_ch.distance,
                 '{rsp_ch.point_x, rsp_ch.point_y, rsp_ch.point_z}};
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
               error_count++;
            end
            if (got.distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h", $time,
                        want.distance, got.distance);
               error_count++;
            end
            if (got.point.x !== want.point.x) begin
               $display("%0t: point_x expected %h actual %h", $time,
                        want.point.x, got.point.x);
               error_count++;
            end
            if (got.point.y !== want.point.y) begin
               $display("%0t: point_y expected %h actual %h", $time,
                        want.point.y, got.point.y);
               error_count++;
            end
            if (got.point.z !== want.point.z) begin
               $display("%0t: point_z expected %h actual %h", $time,
                        want.point.z, got.point.z);
               error_count++;
            end
         end
      end
   end

   // Result receiver with random stalls and an occasional long hold-off.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 10);
         if (hold_request) begin
            stall = 400;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Offers one triangle, after a random gap unless steady_flow is set, and records its prediction on transfer.
   task automatic send_triangle(input rti_pkg::trgl_type tr);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.a_x <= tr.a.x; req_ch.a_y <= tr.a.y; req_ch.a_z <= tr.a.z;
      req_ch.b_x <= tr.b.x; req_ch.b_y <= tr.b.y; req_ch.b_z <= tr.b.z;
      req_ch.c_x <= tr.c.x; req_ch.c_y <= tr.c.y; req_ch.c_z <= tr.c.z;
      do @(posedge clock); while (!req_ch.ready);
      expected_hits.push_back(predict_intersection(tr));
   endtask

   // Waits until every predicted result has come or the guard reaches DRAIN_LIMIT, then lets the pipeline settle.
   task automatic wait_drained();
      int guard;
      req_ch.valid <= 1'b0;
      guard = 0;
      while (expected_hits.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   // One register write; the block is idle whenever this is called.
   task automatic write_csr(input rti_pkg::csr_index_type idx, input logic [31:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         rti_pkg::CSR_ORIGIN_X:    ray_org[0] = data;
         rti_pkg::CSR_ORIGIN_Y:    ray_org[1] = data;
         rti_pkg::CSR_ORIGIN_Z:    ray_org[2] = data;
         rti_pkg::CSR_DIRECTION_X: ray_dir[0] = data;
         rti_pkg::CSR_DIRECTION_Y: ray_dir[1] = data;
         rti_pkg::CSR_DIRECTION_Z: ray_dir[2] = data;
         rti_pkg::CSR_THRESHOLD:   ray_thr = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_ray(input rti_pkg::coord_type ox, oy, oz, dx, dy, dz,
                          input logic [31:0] thr);
      write_csr(rti_pkg::CSR_ORIGIN_X, ox);
      write_csr(rti_pkg::CSR_ORIGIN_Y, oy);
      write_csr(rti_pkg::CSR_ORIGIN_Z, oz);
      write_csr(rti_pkg::CSR_DIRECTION_X, dx);
      write_csr(rti_pkg::CSR_DIRECTION_Y, dy);
      write_csr(rti_pkg::CSR_DIRECTION_Z, dz);
      write_csr(rti_pkg::CSR_THRESHOLD, thr);
   endtask

   function automatic rti_pkg::coord_type rand_span(int unsigned span);
      return rti_pkg::coord_type'($urandom_range(0, 2 * span)) - rti_pkg::coord_type'(span);
   endfunction

   // Triangle whose centroid lies on the ray at a random parameter.
   function automatic rti_pkg::trgl_type aimed_triangle();
      rti_pkg::trgl_type  tr;
      rti_pkg::coord_type cx [3];
      rti_pkg::coord_type e1 [3];
      rti_pkg::coord_type e2 [3];
      rti_pkg::coord_type t0;
      t0 = ($urandom_range(0, 7) == 0)
           ? -rti_pkg::coord_type'($urandom_range(1, 1 << 18))
           : rti_pkg::coord_type'($urandom_range(1, 1 << 18));
      for (int i = 0; i < 3; i++) begin
         cx[i] = ray_org[i] + rti_pkg::coord_type'((64'(ray_dir[i]) * 64'(t0))
                                                   >>> rti_pkg::FRAC_BITS);
         e1[i] = rand_span(1 << 21);
         e2[i] = rand_span(1 << 21);
      end
      tr.a = '{cx[0] + e1[0], cx[1] + e1[1], cx[2] + e1[2]};
      tr.b = '{cx[0] + e2[0], cx[1] + e2[1], cx[2] + e2[2]};
      tr.c = '{cx[0] - e1[0] - e2[0], cx[1] - e1[1] - e2[1], cx[2] - e1[2] - e2[2]};
      return tr;
   endfunction

   function automatic rti_pkg::trgl_type noise_triangle();
      rti_pkg::trgl_type tr;
      tr = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
      return tr;
   endfunction

   function automatic rti_pkg::trgl_type flat_triangle(input rti_pkg::coord_type ax, ay,
                                                       bx, by, cx, cy, z);
      rti_pkg::trgl_type tr;
      tr.a = '{ax, ay, z};
      tr.b = '{bx, by, z};
      tr.c = '{cx, cy, z};
      return tr;
   endfunction

   // Reset ray: plain hits, misses and the boundary cases of the barycentric test.
   task automatic test_reset_ray();
      localparam rti_pkg::coord_type ONE = 32'sh0001_0000;
      send_triangle(flat_triangle(-ONE, -ONE, ONE, -ONE, 0, ONE, 5 * ONE));
      // Ray through a vertex: u and v both zero.
      send_triangle(flat_triangle(0, 0, ONE, 0, 0, ONE, 3 * ONE));
      // Ray through the centroid: u and v both one third.
      send_triangle(flat_triangle(ONE, 0, 0, -ONE, -ONE, ONE, 2 * ONE));
      // Ray through the corner opposite: u equal to one.
      send_triangle(flat_triangle(ONE, ONE, 0, 0, ONE, -ONE, 2 * ONE));
      // Triangle behind the origin and one just outside.
      send_triangle(flat_triangle(-ONE, -ONE, ONE, -ONE, 0, ONE, -4 * ONE));
      send_triangle(flat_triangle(ONE, ONE, 2 * ONE, ONE, ONE, 2 * ONE, ONE));
      // Triangle in the plane of the ray: zero determinant.
      send_triangle('{'{0, -ONE, ONE}, '{0, ONE, 2 * ONE}, '{0, ONE, 3 * ONE}});
      // Degenerate and extreme vertices.
      send_triangle('0);
      send_triangle({9{32'h7FFF_FFFF}});
      send_triangle({9{32'h8000_0000}});
      send_triangle('{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
                      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                      '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}});
      // Triangle through the origin, a miss, and a hit at the smallest nonzero distance.
      send_triangle(flat_triangle(-ONE, -ONE, ONE, -ONE, 0, ONE, 0));
      send_triangle(flat_triangle(-ONE, -ONE, ONE, -ONE, 0, ONE, 1));
      wait_drained();
   endtask

   // Extreme registers: saturated distance and point, threshold edges.
   task automatic test_extreme_config();
      localparam rti_pkg::coord_type ONE = 32'sh0001_0000;
      // Threshold zero still rejects a zero determinant.
      set_ray(0, 0, 0, 0, 0, ONE, 0);
      send_triangle('{'{0, -ONE, ONE}, '{0, ONE, 2 * ONE}, '{0, ONE, 3 * ONE}});
      send_triangle(flat_triangle(-1, -1, 1, -1, 0, 1, ONE));
      wait_drained();
      // Tiny direction with a far plane saturates the distance.
      set_ray(0, 0, 0, 0, 0, 1, 0);
      send_triangle(flat_triangle(-ONE, -ONE, ONE, -ONE, 0, ONE, 32'sh4000_0000));
      wait_drained();
      // Origin near the top of the range pushes the point into saturation.
      set_ray(32'sh7FFF_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
              ONE, 0);
      send_triangle(aimed_triangle());
      send_triangle(flat_triangle(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                  32'sh7FFF_FFFF, 0, 0, 2 * ONE));
      send_triangle(noise_triangle());
      wait_drained();
      // Maximum threshold with a full-range triangle and a random one.
      set_ray(0, 0, 0, 0, 0, ONE, 32'hFFFF_FFFF);
      send_triangle(flat_triangle(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                  32'sh8000_0000, 0, 32'sh7FFF_FFFF, ONE));
      send_triangle(noise_triangle());
      wait_drained();
   endtask

   // Long receiver hold-off while triangles keep coming, then a full pause and more triangles with random gaps.
   task automatic test_backpressure();
      set_ray(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
              rand_span(1 << 17), rand_span(1 << 17), 32'sh0001_0000, 1);
      steady_flow = 1'b1;
      hold_request = 1'b1;
      repeat (120) send_triangle(aimed_triangle());
      steady_flow = 1'b0;
      wait_drained();
      repeat (60) send_triangle(aimed_triangle());
      wait_drained();
   endtask

   // Random rays, mostly aimed triangles with some noise.
   task automatic test_random_rays();
      for (int phase = 0; phase < 8; phase++) begin
         set_ray(rand_span(1 << 22), rand_span(1 << 22), rand_span(1 << 22),
                 rand_span(1 << 18), rand_span(1 << 18), rand_span(1 << 18),
                 (phase % 3 == 0) ? 32'd0 : $urandom_range(0, 4));
         steady_flow = (phase % 4 == 3);
         repeat (210) begin
            if ($urandom_range(0, 3) == 0) send_triangle(noise_triangle());
            else send_triangle(aimed_triangle());
         end
         steady_flow = 1'b0;
         wait_drained();
      end
   endtask

   // Test sequence.
   initial begin
      error_count = 0;
      steady_flow = 1'b0;
      hold_request = 1'b0;
      ray_org = '{0, 0, 0};
      ray_dir = '{0, 0, rti_pkg::DIR_Z_RESET};
      ray_thr = rti_pkg::THR_RESET;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      {req_ch.a_x, req_ch.a_y, req_ch.a_z} <= '0;
      {req_ch.b_x, req_ch.b_y, req_ch.b_z} <= '0;
      {req_ch.c_x, req_ch.c_y, req_ch.c_z} <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= rti_pkg::CSR_ORIGIN_X;
      csr_ch.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_ray();
      test_extreme_config();
      test_backpressure();
      test_random_rays();
      wait_drained();
      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
